@@ hdl/fmtcg_pkg.sv @@
// Shared types, constants and helpers for the FM tuner channel grid block.
package fmtcg_pkg;

	// Frequency words in kHz.
	localparam int KHZ_W = 19;
	localparam int CHAN_W = 10;

	// Shared divider sizes: dividend and quotient width, divisor width.
	localparam int DIV_W = 19;
	localparam int DEN_W = 8;

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	// Synthesizer and register limits.
	localparam logic [KHZ_W-1:0] SYNTH_MIN_KHZ = 19'd50000;
	localparam logic [KHZ_W-1:0] SYNTH_MAX_KHZ = 19'd115000;
	localparam logic [KHZ_W-1:0] REGISTER_MAX_KHZ = 19'd291600;

	// Band edges.
	localparam logic [KHZ_W-1:0] KHZ_50M = 19'd50000;
	localparam logic [KHZ_W-1:0] KHZ_65M = 19'd65000;
	localparam logic [KHZ_W-1:0] KHZ_76M = 19'd76000;
	localparam logic [KHZ_W-1:0] KHZ_87M = 19'd87000;
	localparam logic [KHZ_W-1:0] KHZ_91M = 19'd91000;
	localparam logic [KHZ_W-1:0] KHZ_108M = 19'd108000;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 10'h3FF;

	// Band codes.
	localparam logic [1:0] BAND_EUUS = 2'd0;
	localparam logic [1:0] BAND_JAPAN = 2'd1;
	localparam logic [1:0] BAND_WORLD = 2'd2;
	localparam logic [1:0] BAND_EAST = 2'd3;

	// Spacing codes.
	localparam logic [1:0] SPC_100 = 2'd0;
	localparam logic [1:0] SPC_200 = 2'd1;
	localparam logic [1:0] SPC_50 = 2'd2;
	localparam logic [1:0] SPC_25 = 2'd3;

	// Operation codes.
	localparam logic [1:0] FN_CLAMP = 2'd0;
	localparam logic [1:0] FN_STEP_KHZ = 2'd1;
	localparam logic [1:0] FN_STEP_CHAN = 2'd2;
	localparam logic [1:0] FN_PLAN = 2'd3;

	// Register indexes.
	localparam logic [2:0] REG_BAND = 3'd0;
	localparam logic [2:0] REG_SPACING = 3'd1;
	localparam logic [2:0] REG_EAST65 = 3'd2;
	localparam logic [2:0] REG_STOP = 3'd3;
	localparam logic [2:0] REG_EXT = 3'd4;

	// Command word.
	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] target_khz;
		logic signed [31:0] delta;
		logic [15:0]        wanted_spacing_khz;
	} cmd_t;

	// Result word.
	typedef struct packed {
		logic [KHZ_W-1:0]  result_khz;
		logic [1:0]        planned_band;
		logic [1:0]        planned_spacing;
		logic [CHAN_W-1:0] channel_number;
	} rsp_t;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic [1:0] band_select;
		logic [1:0] spacing_code;
		logic       east_starts_65mhz;
		logic       stop_at_edge;
		logic       extended_range;
	} cfg_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_EDGE,
		ST_CLAMP,
		ST_PLAN,
		ST_DSTART,
		ST_DWAIT,
		ST_POST,
		ST_DONE
	} state_t;

	// Channel spacing in kHz for a spacing code.
	function automatic logic [DEN_W-1:0] spacing_khz(input logic [1:0] code);
		logic [DEN_W-1:0] r;
		case (code)
			SPC_100: r = 8'd100;
			SPC_200: r = 8'd200;
			SPC_50:  r = 8'd50;
			default: r = 8'd25;
		endcase
		return r;
	endfunction

endpackage

@@ hdl/fm_tuner_channel_grid.sv @@
// FM tuner channel grid: band clamp, kHz and channel stepping, and frequency planning.
// A command is taken when start is high and busy is low; busy then stays high until
// the result word has been shown. The result appears on rsp for exactly one cycle with
// done high and must be captured then, since the block cannot be held off. All rounding
// goes through one shared restoring divider that produces one quotient bit per cycle. A kHz
// step adds an edge-handling state before the clamp, and a channel step a multiply state
// before that. A clamp whose target lies on or outside a band edge finishes without a
// division. Planning runs one division per spacing it tries, plus one more when the
// channel must be pulled back under the range maximum.
module fm_tuner_channel_grid (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fmtcg_pkg::ADDR_W-1:0]  paddr,
	input  logic [fmtcg_pkg::DATA_W-1:0]  pwdata,
	output logic [fmtcg_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  fmtcg_pkg::cmd_t               cmd,
	output logic                          done,
	output fmtcg_pkg::rsp_t               rsp
);
	import fmtcg_pkg::*;

	cfg_t cfg;

	state_t state_q;
	state_t state_d;

	// Command and working registers.
	cmd_t               cmd_q;
	logic signed [31:0] d_q;
	logic signed [33:0] f_q;
	logic [KHZ_W-1:0]   base_q;
	logic [KHZ_W-1:0]   off_q;
	logic [KHZ_W-1:0]   max_q;
	logic [DIV_W-1:0]   num_q;
	logic               fix_q;
	logic [KHZ_W-1:0]   res_q;
	logic [1:0]         pband_q;
	logic [1:0]         pspace_q;
	logic [CHAN_W-1:0]  chan_q;

	// Divider interface.
	logic             div_start;
	logic             div_done;
	logic [DIV_W-1:0] quo;

	logic accept;

	fmtcg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmtcg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (spacing_khz(pspace_q)),
		.done   (div_done),
		.quo    (quo)
	);

	assign accept = start && (state_q == ST_IDLE);

	// Band limits from the configuration.
	logic [KHZ_W-1:0] lo;
	logic [KHZ_W-1:0] hi;

	always_comb begin
		case (cfg.band_select) inside
			BAND_JAPAN, BAND_WORLD: lo = KHZ_76M;
			BAND_EAST:              lo = cfg.east_starts_65mhz ? KHZ_65M : KHZ_50M;
			default:                lo = KHZ_87M;
		endcase
		case (cfg.band_select)
			BAND_JAPAN: hi = KHZ_91M;
			BAND_EAST:  hi = KHZ_76M;
			default:    hi = KHZ_108M;
		endcase
	end

	logic signed [33:0] lo_s;
	logic signed [33:0] hi_s;
	logic [DEN_W-1:0]   st;
	logic [DEN_W-1:0]   half_st;

	assign lo_s = $signed({15'b0, lo});
	assign hi_s = $signed({15'b0, hi});
	assign st = spacing_khz(pspace_q);
	assign half_st = {1'b0, st[DEN_W-1:1]};

	// Channel step: delta times spacing, saturated to 32 bits.
	logic signed [40:0] prod;
	logic               prod_fits;
	logic signed [31:0] prod_sat;

	always_comb begin
		prod = 41'(cmd_q.delta) * 41'($signed({1'b0, st}));
		prod_fits = (prod[40:31] == '0) || (prod[40:31] == '1);
		if (prod_fits) begin
			prod_sat = prod[31:0];
		end else if (prod[40]) begin
			prod_sat = 32'sh8000_0000;
		end else begin
			prod_sat = 32'sh7FFF_FFFF;
		end
	end

	// Step: unsigned current frequency plus signed delta, then edge handling.
	logic signed [33:0] nxt;
	logic signed [33:0] edged;

	always_comb begin
		nxt = $signed({2'b00, cmd_q.target_khz}) + $signed({{2{d_q[31]}}, d_q});
		if (nxt > hi_s) begin
			edged = cfg.stop_at_edge ? hi_s : lo_s;
		end else if (nxt < lo_s) begin
			edged = cfg.stop_at_edge ? lo_s : hi_s;
		end else begin
			edged = nxt;
		end
	end

	// Clamp: out-of-band checks and the rounding dividend.
	logic               f_le_lo;
	logic               f_ge_hi;
	logic signed [33:0] f_off;
	logic [DIV_W-1:0]   clamp_num;

	always_comb begin
		f_le_lo = f_q <= lo_s;
		f_ge_hi = f_q >= hi_s;
		f_off = f_q - lo_s;
		clamp_num = f_off[DIV_W-1:0] + DIV_W'(half_st);
	end

	// Planning set-up: limited request, band base and first spacing.
	logic [KHZ_W-1:0] plan_max;
	logic [KHZ_W-1:0] req;
	logic [KHZ_W-1:0] plan_base;
	logic [1:0]       plan_band;
	logic [1:0]       plan_spc;
	logic [KHZ_W-1:0] plan_off;
	logic [DEN_W-1:0] plan_st;
	logic [DIV_W-1:0] plan_num;

	always_comb begin
		plan_max = cfg.extended_range ? REGISTER_MAX_KHZ : SYNTH_MAX_KHZ;
		if (cmd_q.target_khz <= $signed({13'b0, SYNTH_MIN_KHZ})) begin
			req = SYNTH_MIN_KHZ;
		end else if (cmd_q.target_khz >= $signed({13'b0, plan_max})) begin
			req = plan_max;
		end else begin
			req = cmd_q.target_khz[KHZ_W-1:0];
		end

		if (req < KHZ_76M) begin
			plan_band = BAND_EAST;
			plan_base = KHZ_50M;
		end else if (req < KHZ_87M) begin
			plan_band = BAND_WORLD;
			plan_base = KHZ_76M;
		end else begin
			plan_band = BAND_EUUS;
			plan_base = KHZ_87M;
		end

		if (cmd_q.wanted_spacing_khz <= 16'd25) begin
			plan_spc = SPC_25;
		end else if (cmd_q.wanted_spacing_khz <= 16'd50) begin
			plan_spc = SPC_50;
		end else if (cmd_q.wanted_spacing_khz <= 16'd100) begin
			plan_spc = SPC_100;
		end else begin
			plan_spc = SPC_200;
		end

		plan_off = (req > plan_base) ? (req - plan_base) : '0;
		plan_st = spacing_khz(plan_spc);
		plan_num = plan_off + DIV_W'(plan_st[DEN_W-1:1]);
	end

	// Post-division: shared multiply-add for base plus channel times spacing.
	logic              is_plan;
	logic              q_big;
	logic [CHAN_W-1:0] chan_sat;
	logic [11:0]       mul_in;
	logic [19:0]       mul_out;
	logic [KHZ_W-1:0]  add_base;
	logic [KHZ_W-1:0]  post_res;
	logic              widen;
	logic              over_max;
	logic [1:0]        wide_spc;
	logic [DEN_W-1:0]  wide_st;
	logic [DIV_W-1:0]  wide_num;

	always_comb begin
		is_plan = cmd_q.func == FN_PLAN;
		q_big = |quo[DIV_W-1:CHAN_W];
		chan_sat = q_big ? CHAN_MAX : quo[CHAN_W-1:0];
		mul_in = is_plan ? 12'(chan_sat) : quo[11:0];
		mul_out = 20'(mul_in) * 20'(st);
		add_base = is_plan ? base_q : lo;
		post_res = add_base + mul_out[KHZ_W-1:0];
		widen = !fix_q && q_big && (pspace_q != SPC_200);
		over_max = !fix_q && (post_res > max_q);

		case (pspace_q)
			SPC_25:  wide_spc = SPC_50;
			SPC_50:  wide_spc = SPC_100;
			default: wide_spc = SPC_200;
		endcase
		wide_st = spacing_khz(wide_spc);
		wide_num = off_q + DIV_W'(wide_st[DEN_W-1:1]);
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.func)
						FN_CLAMP:     state_d = ST_CLAMP;
						FN_STEP_KHZ:  state_d = ST_EDGE;
						FN_STEP_CHAN: state_d = ST_MUL;
						default:      state_d = ST_PLAN;
					endcase
				end
			end
			ST_MUL:    state_d = ST_EDGE;
			ST_EDGE:   state_d = ST_CLAMP;
			ST_CLAMP:  state_d = (f_le_lo || f_ge_hi) ? ST_DONE : ST_DSTART;
			ST_PLAN:   state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (div_done) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				if (is_plan && (widen || over_max)) begin
					state_d = ST_DSTART;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		busy = state_q != ST_IDLE;
		done = state_q == ST_DONE;
		div_start = state_q == ST_DSTART;
	end

	// Working datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q <= cmd;
					d_q <= cmd.delta;
					f_q <= {{2{cmd.target_khz[31]}}, cmd.target_khz};
					pband_q <= cfg.band_select;
					pspace_q <= cfg.spacing_code;
					chan_q <= '0;
					fix_q <= 1'b0;
				end
			end
			ST_MUL: begin
				d_q <= prod_sat;
			end
			ST_EDGE: begin
				f_q <= edged;
			end
			ST_CLAMP: begin
				num_q <= clamp_num;
				if (f_le_lo) begin
					res_q <= lo;
				end else if (f_ge_hi) begin
					res_q <= hi;
				end
			end
			ST_PLAN: begin
				max_q <= plan_max;
				base_q <= plan_base;
				off_q <= plan_off;
				pband_q <= plan_band;
				pspace_q <= plan_spc;
				num_q <= plan_num;
			end
			ST_POST: begin
				if (!is_plan) begin
					res_q <= (post_res > hi) ? hi : post_res;
				end else if (widen) begin
					pspace_q <= wide_spc;
					num_q <= wide_num;
				end else begin
					chan_q <= chan_sat;
					res_q <= post_res;
					if (over_max) begin
						fix_q <= 1'b1;
						num_q <= max_q - base_q;
					end
				end
			end
			default: ;
		endcase
	end

	// Result word.
	always_comb begin
		rsp.result_khz = res_q;
		rsp.planned_band = pband_q;
		rsp.planned_spacing = pspace_q;
		rsp.channel_number = chan_q;
	end

endmodule

@@ hdl/fmtcg_div.sv @@
// Restoring divider, one quotient bit per cycle, shared by all operations.
module fmtcg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fmtcg_pkg::DIV_W-1:0]  num,
	input  logic [fmtcg_pkg::DEN_W-1:0]  den,
	output logic                         done,
	output logic [fmtcg_pkg::DIV_W-1:0]  quo
);
	import fmtcg_pkg::*;

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             active_q;
	logic             done_q;
	logic [DEN_W:0]   trial;
	logic             fits;
	logic [DEN_W:0]   diff;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		trial = {rem_q, quo_q[DIV_W-1]};
		fits = trial >= {1'b0, den_q};
		diff = trial - {1'b0, den_q};
	end

	// Control: iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			active_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
				active_q <= 1'b1;
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (active_q) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign done = done_q;
	assign quo = quo_q;

endmodule

@@ hdl/fmtcg_regs.sv @@
// Configuration register file behind the APB-style port.
module fmtcg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fmtcg_pkg::ADDR_W-1:0]  paddr,
	input  logic [fmtcg_pkg::DATA_W-1:0]  pwdata,
	output logic [fmtcg_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output fmtcg_pkg::cfg_t               cfg
);
	import fmtcg_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx = paddr[ADDR_W-1:2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	// Register writes; addresses past the last register are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_select <= BAND_EUUS;
			cfg_q.spacing_code <= SPC_100;
			cfg_q.east_starts_65mhz <= 1'b1;
			cfg_q.stop_at_edge <= 1'b0;
			cfg_q.extended_range <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_BAND:    cfg_q.band_select <= pwdata[1:0];
				REG_SPACING: cfg_q.spacing_code <= pwdata[1:0];
				REG_EAST65:  cfg_q.east_starts_65mhz <= pwdata[0];
				REG_STOP:    cfg_q.stop_at_edge <= pwdata[0];
				REG_EXT:     cfg_q.extended_range <= pwdata[0];
				default:     ;
			endcase
		end
	end

	// Read-back.
	always_comb begin
		unique case (idx)
			REG_BAND:    prdata = DATA_W'(cfg_q.band_select);
			REG_SPACING: prdata = DATA_W'(cfg_q.spacing_code);
			REG_EAST65:  prdata = DATA_W'(cfg_q.east_starts_65mhz);
			REG_STOP:    prdata = DATA_W'(cfg_q.stop_at_edge);
			REG_EXT:     prdata = DATA_W'(cfg_q.extended_range);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule
